// File: hdl/mbl_pkg.sv
// ----------------------------------------------------------------------------
// mbl_pkg: shared types and constants of the minBLEP overlap-add block
// Sizes of the residual table and correction ring, field widths, operation
// codes, the sequencer states and the saturation and slot-increment helpers.
// ----------------------------------------------------------------------------
package mbl_pkg;

    localparam int ZERO_CROSSINGS = 16;
    localparam int OVERSAMPLING   = 64;

    localparam int TABLE_LEN = 2 * ZERO_CROSSINGS * OVERSAMPLING;
    localparam int RING_LEN  = 2 * ZERO_CROSSINGS + 1;

    localparam int TAB_AW   = $clog2(TABLE_LEN);
    localparam int IDX_W    = $clog2(TABLE_LEN + OVERSAMPLING);
    localparam int SLOT_W   = $clog2(RING_LEN);
    localparam int PHASE_W  = $clog2(OVERSAMPLING + 1);

    // Fixed field widths of the item and result.
    localparam int OP_W     = 2;
    localparam int TIDX_W   = 11;
    localparam int RES_W    = 16;
    localparam int AMP_W    = 16;
    localparam int FRAC_W   = 17;
    localparam int ACC_W    = 24;
    localparam int PROD_W   = AMP_W + RES_W;
    localparam int PROD_SHIFT = 15;

    // Phase rounding: ((ONE - f) * OVERSAMPLING + HALF) >> 16.
    localparam int PH_SUM_W = FRAC_W + $clog2(OVERSAMPLING) + 1;
    localparam logic [FRAC_W-1:0]   FRAC_ONE  = FRAC_W'(65536);
    localparam logic [PH_SUM_W-1:0] PH_ROUND  = PH_SUM_W'(32768);
    localparam int                  PH_SHIFT  = 16;

    localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
    localparam logic [OP_W-1:0] OP_SCHED = 2'd1;
    localparam logic [OP_W-1:0] OP_NEXT  = 2'd2;

    localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_DRAIN,
        S_NEXT
    } t_state;

    // One multiply-add step launched toward the shared unit.
    typedef struct packed {
        logic              valid;
        logic [SLOT_W-1:0] slot;
    } t_mac_issue;

    // Write of one correction ring slot.
    typedef struct packed {
        logic                    en;
        logic [SLOT_W-1:0]       addr;
        logic signed [ACC_W-1:0] data;
    } t_ring_wr;

    // Saturate a sum that grew by one bit back to the accumulator width.
    function automatic logic signed [ACC_W-1:0] f_sat(input logic signed [ACC_W:0] v);
        logic signed [ACC_W-1:0] r;
        if (v[ACC_W] != v[ACC_W-1]) begin
            r = v[ACC_W] ? ACC_MIN : ACC_MAX;
        end else begin
            r = v[ACC_W-1:0];
        end
        return r;
    endfunction

    function automatic logic [SLOT_W-1:0] f_slot_inc(input logic [SLOT_W-1:0] s);
        logic [SLOT_W-1:0] r;
        if (s == SLOT_W'(RING_LEN - 1)) begin
            r = '0;
        end else begin
            r = s + SLOT_W'(1);
        end
        return r;
    endfunction

endpackage

// File: hdl/mbl_if.sv
// ----------------------------------------------------------------------------
// mbl_if: valid/ready channels of the minBLEP overlap-add block
// The item channel carries one command; the result channel one sample.
// ----------------------------------------------------------------------------
interface mbl_item_if import mbl_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [OP_W-1:0]          operation;
    logic [TIDX_W-1:0]        table_index;
    logic signed [RES_W-1:0]  table_value;
    logic signed [AMP_W-1:0]  amp;
    logic [FRAC_W-1:0]        frac;

    modport source (output valid, operation, table_index, table_value, amp, frac,
                    input ready);
    modport sink   (input valid, operation, table_index, table_value, amp, frac,
                    output ready);
endinterface

interface mbl_result_if import mbl_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [ACC_W-1:0]  sample;

    modport source (output valid, sample, input ready);
    modport sink   (input valid, sample, output ready);
endinterface

// File: hdl/minblep_overlap_add.sv
// ----------------------------------------------------------------------------
// minblep_overlap_add: minBLEP step applicator for one oscillator voice
// Loads a residual table, overlap-adds scaled residuals into a correction
// ring and emits the held level plus the ring head on request.
// ----------------------------------------------------------------------------
// Usage: items arrive on i_item, a valid/ready channel; each carries an
// operation code. A load writes one table word and completes in the cycle
// of its transfer. A schedule step adds the step height to the held level
// at once and then walks the ring: one multiply-add is launched per cycle
// through the shared unit, up to 2*ZERO_CROSSINGS steps, followed by the
// end check and a drain of the unit's two pipeline stages, during all of
// which the input stays closed. The walk runs through the single
// multiply-add unit and the single ring write port. A next request reads
// the head slot at its transfer and loads the result register from the
// S_NEXT state once that register is free. The result register holds
// the sample until the receiver takes it; a further next request is
// taken and then waits in S_NEXT, with the input closed, while it is
// still full. Reset clears the ring (through per-slot valid bits), the
// held level and the head; the residual table keeps no reset and must
// be loaded first.
// ----------------------------------------------------------------------------
module minblep_overlap_add import mbl_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    mbl_item_if.sink      i_item,
    mbl_result_if.source  o_result
);

    // Sequencer and datapath registers.
    t_state                  r_state, n_state;
    logic signed [AMP_W-1:0] r_amp;
    logic [IDX_W-1:0]        r_idx;
    logic [SLOT_W-1:0]       r_slot;
    logic [SLOT_W-1:0]       r_head;
    logic signed [ACC_W-1:0] r_level;
    logic                    r_out_valid;
    logic signed [ACC_W-1:0] r_out_sample;

    // Control decoded from the state.
    logic                    w_accept;
    logic                    w_walk_more;
    logic                    w_out_free;
    logic                    w_out_load;
    t_mac_issue              w_issue;
    logic [SLOT_W-1:0]       w_ring_rd_addr;
    logic                    w_tab_wr_en;

    // Memory and unit connections.
    logic signed [RES_W-1:0] w_res;
    logic signed [ACC_W-1:0] w_ring_rd;
    t_ring_wr                w_ring_wr;
    logic                    w_mac_busy;

    // Phase of the step within the oversampled table.
    logic [FRAC_W-1:0]       w_frac_clamp;
    logic [PH_SUM_W-1:0]     w_ph_sum;
    logic [PHASE_W-1:0]      w_phase;

    logic signed [ACC_W-1:0] w_level_next;
    logic signed [ACC_W-1:0] w_sample;

    assign w_accept    = i_item.valid && i_item.ready;
    assign w_walk_more = 32'(r_idx) < TABLE_LEN;
    assign w_out_free  = !r_out_valid || o_result.ready;

    assign w_frac_clamp = (i_item.frac > FRAC_ONE) ? FRAC_ONE : i_item.frac;
    assign w_ph_sum     = PH_SUM_W'(FRAC_ONE - w_frac_clamp) * PH_SUM_W'(OVERSAMPLING)
                          + PH_ROUND;
    assign w_phase      = PHASE_W'(w_ph_sum >> PH_SHIFT);

    assign w_level_next = f_sat((ACC_W + 1)'(r_level) + (ACC_W + 1)'(i_item.amp));
    assign w_sample     = f_sat((ACC_W + 1)'(r_level) + (ACC_W + 1)'(w_ring_rd));

    // Next-state logic.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept && i_item.operation == OP_SCHED) begin
                    n_state = S_WALK;
                end else if (w_accept && i_item.operation == OP_NEXT) begin
                    n_state = S_NEXT;
                end
            end
            S_WALK: begin
                if (!w_walk_more) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (!w_mac_busy) begin
                    n_state = S_IDLE;
                end
            end
            S_NEXT: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Outputs of the sequencer.
    always_comb begin
        i_item.ready   = 1'b0;
        w_issue        = '0;
        w_out_load     = 1'b0;
        w_ring_rd_addr = r_head;
        w_tab_wr_en    = 1'b0;
        case (r_state)
            S_IDLE: begin
                i_item.ready = 1'b1;
                w_tab_wr_en  = i_item.valid && i_item.operation == OP_LOAD
                               && 32'(i_item.table_index) < TABLE_LEN;
            end
            S_WALK: begin
                w_issue.valid  = w_walk_more;
                w_issue.slot   = r_slot;
                w_ring_rd_addr = r_slot;
            end
            S_DRAIN: begin
                w_ring_rd_addr = r_head;
            end
            S_NEXT: begin
                w_out_load = w_out_free;
            end
            default: begin
                i_item.ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_level     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_accept && i_item.operation == OP_SCHED) begin
                r_level <= w_level_next;
            end
            if (w_out_load) begin
                r_head <= f_slot_inc(r_head);
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Walk registers: table index steps by the oversampling factor and the
    // slot by one, starting at the head.
    always_ff @(posedge i_clk) begin
        if (w_accept && i_item.operation == OP_SCHED) begin
            r_amp  <= i_item.amp;
            r_idx  <= IDX_W'(w_phase);
            r_slot <= r_head;
        end else if (w_issue.valid) begin
            r_idx  <= r_idx + IDX_W'(OVERSAMPLING);
            r_slot <= f_slot_inc(r_slot);
        end
        if (w_out_load) begin
            r_out_sample <= w_sample;
        end
    end

    assign o_result.valid  = r_out_valid;
    assign o_result.sample = r_out_sample;

    mbl_table u_table (
        .i_clk     (i_clk),
        .i_wr_en   (w_tab_wr_en),
        .i_wr_addr (TAB_AW'(i_item.table_index)),
        .i_wr_data (i_item.table_value),
        .i_rd_addr (r_idx[TAB_AW-1:0]),
        .o_rd_data (w_res)
    );

    mbl_ring u_ring (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr       (w_ring_wr),
        .i_clr_en   (w_out_load),
        .i_clr_addr (r_head),
        .i_rd_addr  (w_ring_rd_addr),
        .o_rd_data  (w_ring_rd)
    );

    mbl_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_issue (w_issue),
        .i_amp   (r_amp),
        .i_res   (w_res),
        .i_acc   (w_ring_rd),
        .o_wr    (w_ring_wr),
        .o_busy  (w_mac_busy)
    );

endmodule

// File: hdl/mbl_table.sv
// ----------------------------------------------------------------------------
// mbl_table: residual table storage
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module mbl_table import mbl_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_wr_en,
    input  logic [TAB_AW-1:0]       i_wr_addr,
    input  logic signed [RES_W-1:0] i_wr_data,
    input  logic [TAB_AW-1:0]       i_rd_addr,
    output logic signed [RES_W-1:0] o_rd_data
);

    logic signed [RES_W-1:0] r_mem [TABLE_LEN];
    logic signed [RES_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: hdl/mbl_ring.sv
// ----------------------------------------------------------------------------
// mbl_ring: correction ring of accumulators
// A small memory with registered read and one valid bit per slot; a slot
// whose valid bit is clear reads as zero, so a slot is cleared by clearing its valid bit.
// ----------------------------------------------------------------------------
module mbl_ring import mbl_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_ring_wr                i_wr,
    input  logic                    i_clr_en,
    input  logic [SLOT_W-1:0]       i_clr_addr,
    input  logic [SLOT_W-1:0]       i_rd_addr,
    output logic signed [ACC_W-1:0] o_rd_data
);

    logic signed [ACC_W-1:0] r_mem [RING_LEN];
    logic [RING_LEN-1:0]     r_valid;
    logic signed [ACC_W-1:0] r_rd_data;
    logic                    r_rd_valid;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            r_rd_valid <= r_valid[i_rd_addr];
            if (i_clr_en) begin
                r_valid[i_clr_addr] <= 1'b0;
            end
            if (i_wr.en) begin
                r_valid[i_wr.addr] <= 1'b1;
            end
        end
    end

    assign o_rd_data = r_rd_valid ? r_rd_data : '0;

endmodule

// File: hdl/mbl_mac.sv
// ----------------------------------------------------------------------------
// mbl_mac: shared multiply-accumulate unit
// Multiplies the step height by a residual word, shifts the product to the
// accumulator scale, adds the ring slot and saturates: one step per cycle.
// ----------------------------------------------------------------------------
module mbl_mac import mbl_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_mac_issue              i_issue,
    input  logic signed [AMP_W-1:0] i_amp,
    input  logic signed [RES_W-1:0] i_res,
    input  logic signed [ACC_W-1:0] i_acc,
    output t_ring_wr                o_wr,
    output logic                    o_busy
);

    // Stage 1 follows the memory read, stage 2 holds the product.
    t_mac_issue               r_s1;
    t_mac_issue               r_s2;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0]  r_acc;

    logic signed [ACC_W:0]    w_term;
    logic signed [ACC_W:0]    w_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1 <= '0;
            r_s2 <= '0;
        end else begin
            r_s1 <= i_issue;
            r_s2 <= r_s1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= i_amp * i_res;
        r_acc  <= i_acc;
    end

    assign w_term = (ACC_W + 1)'(r_prod >>> PROD_SHIFT);
    assign w_sum  = (ACC_W + 1)'(r_acc) + w_term;

    always_comb begin
        o_wr.en   = r_s2.valid;
        o_wr.addr = r_s2.slot;
        o_wr.data = f_sat(w_sum);
    end

    assign o_busy = r_s1.valid | r_s2.valid;

endmodule

// File: bench/tb_mbl_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_mbl_checker: result predictor and comparator for minblep_overlap_add
// Watches both channels. Accepted loads, schedules and nexts update a
// private copy of the residual table, correction ring, held level and
// head. Each next queues its sample, and each accepted result is
// compared with the oldest queued sample.
// ----------------------------------------------------------------------------
module tb_mbl_checker import mbl_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    mbl_item_if   i_item,
    mbl_result_if i_result,
    output int    o_errors,
    output int    o_pending
);

    localparam longint SAT_HI = (longint'(1) <<< (ACC_W - 1)) - 1;
    localparam longint SAT_LO = -(longint'(1) <<< (ACC_W - 1));

    logic signed [RES_W-1:0] residue_mem [TABLE_LEN];
    logic signed [ACC_W-1:0] ring_acc [RING_LEN];
    logic signed [ACC_W-1:0] level_acc;
    int                      head_slot;
    logic signed [ACC_W-1:0] sample_q [$];

    function automatic logic signed [ACC_W-1:0] clip_acc(input longint v);
        longint c;
        c = (v > SAT_HI) ? SAT_HI : ((v < SAT_LO) ? SAT_LO : v);
        return c[ACC_W-1:0];
    endfunction

    // Overlap-add of one scaled residual column into the ring, and of the step height into the held level.
    task automatic add_step(input logic signed [AMP_W-1:0] amp,
                            input logic [FRAC_W-1:0] frac);
        longint f;
        longint phase;
        longint idx;
        longint prod;
        int     slot;
        int     n;
        f = (frac > FRAC_ONE) ? longint'(FRAC_ONE) : longint'(frac);
        phase = ((65536 - f) * OVERSAMPLING + 32768) >>> 16;
        for (n = 0; n < 2 * ZERO_CROSSINGS; n++) begin
            idx = n * OVERSAMPLING + phase;
            if (idx >= TABLE_LEN) begin
                break;
            end
            slot = (head_slot + n) % RING_LEN;
            prod = longint'(amp) * longint'(residue_mem[idx]);
            ring_acc[slot] = clip_acc(longint'(ring_acc[slot]) + (prod >>> PROD_SHIFT));
        end
        level_acc = clip_acc(longint'(level_acc) + longint'(amp));
    endtask

    task automatic note_mismatch(input string what, input longint want, input longint got);
        o_errors++;
        if (o_errors <= 10) begin
            $display("%0t: %s: expected %0d, got %0d", $realtime, what, want, got);
        end
    endtask

    always @(posedge i_clk) begin : watch
        logic signed [ACC_W-1:0] want;
        if (!i_rst_n) begin
            foreach (ring_acc[k]) ring_acc[k] = '0;
            level_acc = '0;
            head_slot = 0;
            o_errors  = 0;
            sample_q.delete();
        end else begin
            if (i_item.valid && i_item.ready) begin
                case (i_item.operation)
                    OP_LOAD: begin
                        if (i_item.table_index < TABLE_LEN) begin
                            residue_mem[i_item.table_index] = i_item.table_value;
                        end
                    end
                    OP_SCHED: add_step(i_item.amp, i_item.frac);
                    OP_NEXT: begin
                        sample_q.push_back(clip_acc(longint'(level_acc) +
                                                    longint'(ring_acc[head_slot])));
                        ring_acc[head_slot] = '0;
                        head_slot = (head_slot + 1) % RING_LEN;
                    end
                    default: ;
                endcase
            end
            if (i_result.valid && i_result.ready) begin
                if (sample_q.size() == 0) begin
                    note_mismatch("sample with no request", 0, i_result.sample);
                end else begin
                    want = sample_q.pop_front();
                    if (i_result.sample !== want) begin
                        note_mismatch("sample", want, i_result.sample);
                    end
                end
            end
        end
        o_pending = sample_q.size();
    end

endmodule

// File: bench/tb_minblep_overlap_add.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_minblep_overlap_add: stimulus and verdict for minblep_overlap_add
// Loads the residual columns that steps may read, runs a short directed set
// of commands, then random commands with two long pile-ups of same-sign
// steps that drive the ring and the held level into saturation. Both
// channels idle at random.
// ----------------------------------------------------------------------------
module tb_minblep_overlap_add import mbl_pkg::*; ();

    // The fourth operation code is unused; the block drops such commands.
    localparam logic [OP_W-1:0] OP_SPARE = 2'd3;

    // Long enough for any schedule walk and drain still in flight once the
    // last sample is in.
    localparam int SETTLE_CYCLES = 2 * ZERO_CROSSINGS + 12;

    // Residual columns that are pinned to full scale so that a step at a
    // known phase adds the largest possible correction to every slot.
    localparam int COL_POS = 0;
    localparam int COL_NEG = OVERSAMPLING / 2;

    // Only a handful of table columns is loaded, and steps are placed only
    // at phases that read those columns. The top phase reads column zero
    // shifted by one sample.
    localparam int N_COLS    = 8;
    localparam int FRAC_STEP = 65536 / OVERSAMPLING;

    localparam logic [FRAC_W-1:0] FRAC_MAX = '1;

    logic clk;
    logic rst_n;
    int   tx_gap_max;
    int   rx_gap_max;
    int   error_count;
    int   pending_count;

    mbl_item_if   item_ch ();
    mbl_result_if result_ch ();

    minblep_overlap_add DUT (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_item  (item_ch),
        .o_result(result_ch)
    );

    tb_mbl_checker checker_0 (
        .i_clk    (clk),
        .i_rst_n  (rst_n),
        .i_item   (item_ch),
        .i_result (result_ch),
        .o_errors (error_count),
        .o_pending(pending_count)
    );

    initial clk = 1'b0;
    always #4 clk = ~clk;

    // Hard stop in case the block hangs. The slowest legal run is well
    // under a quarter of this.
    initial begin
        #8_000_000;
        $display("simulation failed");
        $finish;
    end

    // Table column loaded in slot i of the loaded set.
    function automatic int load_col(input int i);
        int c;
        case (i)
            0: c = COL_POS;
            1: c = 1;
            2: c = 17;
            3: c = 31;
            4: c = COL_NEG;
            5: c = 33;
            6: c = 48;
            default: c = OVERSAMPLING - 1;
        endcase
        return c;
    endfunction

    // One command transfer. The sender first waits a random number of
    // cycles with valid low, then holds the command until it is taken.
    // With no gap, valid stays high straight into the next command.
    task automatic send_cmd(input logic [OP_W-1:0] op, input logic [TIDX_W-1:0] idx,
                            input logic signed [RES_W-1:0] val,
                            input logic signed [AMP_W-1:0] amp,
                            input logic [FRAC_W-1:0] frac);
        int gap;
        if ($urandom_range(0, 39) == 0) begin
            tx_gap_max = $urandom_range(0, 1) ? 8 : 0;
        end
        gap = $urandom_range(0, tx_gap_max);
        repeat (gap) begin
            @(negedge clk);
            item_ch.valid <= 1'b0;
        end
        @(negedge clk);
        item_ch.valid       <= 1'b1;
        item_ch.operation   <= op;
        item_ch.table_index <= idx;
        item_ch.table_value <= val;
        item_ch.amp         <= amp;
        item_ch.frac        <= frac;
        do @(posedge clk); while (!item_ch.ready);
    endtask

    // Hold the input quiet until every requested sample has come back.
    task automatic hold_until_drained();
        @(negedge clk);
        item_ch.valid <= 1'b0;
        while (pending_count != 0) @(negedge clk);
    endtask

    // Step heights: mostly uniform over the whole range, sometimes an extreme or zero.
    function automatic logic signed [AMP_W-1:0] pick_amp();
        logic signed [AMP_W-1:0] a;
        case ($urandom_range(0, 15))
            0: a = 16'sh7FFF;
            1: a = 16'sh8000;
            2: a = '0;
            default: a = AMP_W'($urandom());
        endcase
        return a;
    endfunction

    // Step positions: mostly anywhere within the rounding window of a
    // loaded phase, with the ends of the range and values above one that
    // the block has to clamp.
    function automatic logic [FRAC_W-1:0] pick_frac();
        logic [FRAC_W-1:0] f;
        int                p;
        int                lo;
        int                hi;
        if ($urandom_range(0, N_COLS) == 0) begin
            p = OVERSAMPLING;
        end else begin
            p = load_col($urandom_range(0, N_COLS - 1));
        end
        lo = 65536 - p * FRAC_STEP - (FRAC_STEP / 2 - 1);
        hi = 65536 - p * FRAC_STEP + FRAC_STEP / 2;
        if (lo < 0) begin
            lo = 0;
        end
        if (hi > 65536) begin
            hi = 65536;
        end
        case ($urandom_range(0, 15))
            0: f = '0;
            1: f = FRAC_ONE;
            2: f = FRAC_MAX;
            3, 4: f = FRAC_W'($urandom_range(65537, 131071));
            default: f = FRAC_W'($urandom_range(hi, lo));
        endcase
        return f;
    endfunction

    // A run of random commands. Dropped commands do not count toward n.
    task automatic random_cmds(input int n);
        int                      done;
        int                      r;
        logic [OP_W-1:0]         op;
        logic signed [RES_W-1:0] val;
        done = 0;
        while (done < n) begin
            r = $urandom_range(0, 99);
            if (r < 15) begin
                op = OP_LOAD;
            end else if (r < 55) begin
                op = OP_SCHED;
            end else if (r < 96) begin
                op = OP_NEXT;
            end else begin
                op = OP_SPARE;
            end
            val = ($urandom_range(0, 7) == 0) ? pick_amp() : RES_W'($urandom());
            send_cmd(op, TIDX_W'($urandom()), val, pick_amp(), pick_frac());
            if (op != OP_SPARE) begin
                done++;
            end
        end
    endtask

    // Many near-full-scale steps of one sign at phase zero with no next in
    // between. The head stays put, so the held level and most ring slots
    // run into saturation; the nexts that follow read out and clear the
    // whole ring, so the output saturates as well.
    task automatic pile_up(input logic negative, input int steps);
        int                      j;
        logic signed [AMP_W-1:0] a;
        repeat (steps) begin
            j = $urandom_range(0, 767);
            a = negative ? AMP_W'(-32768 + j) : AMP_W'(32767 - j);
            send_cmd(OP_SCHED, TIDX_W'($urandom()), RES_W'($urandom()), a,
                     FRAC_W'($urandom_range(65536, 131071)));
        end
        repeat (40) send_cmd(OP_NEXT, TIDX_W'($urandom()), RES_W'($urandom()),
                             AMP_W'($urandom()), FRAC_W'($urandom()));
    endtask

    // Receiver: before each sample it waits a random number of cycles
    // with ready low, then keeps ready high until a transfer happens.
    // Every so often it switches between stalling and taking at full rate.
    initial begin : rx_side
        int gap;
        result_ch.ready = 1'b0;
        rx_gap_max      = 8;
        forever begin
            if ($urandom_range(0, 31) == 0) begin
                rx_gap_max = $urandom_range(0, 1) ? 8 : 0;
            end
            gap = $urandom_range(0, rx_gap_max);
            repeat (gap) begin
                @(negedge clk);
                result_ch.ready <= 1'b0;
            end
            @(negedge clk);
            result_ch.ready <= 1'b1;
            do @(posedge clk); while (!result_ch.valid);
        end
    end

    initial begin : tx_side
        logic signed [RES_W-1:0] word;
        int                      k;
        int                      c;
        int                      col;
        item_ch.valid       = 1'b0;
        item_ch.operation   = OP_LOAD;
        item_ch.table_index = '0;
        item_ch.table_value = '0;
        item_ch.amp         = '0;
        item_ch.frac        = '0;
        tx_gap_max          = 8;
        rst_n               = 1'b0;
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;

        // Fill every loaded column before any step reads it. One column is
        // pinned to the positive and one to the negative full scale; the
        // rest is random. Every address bit takes both values.
        for (c = 0; c < N_COLS; c++) begin
            col = load_col(c);
            for (k = 0; k < 2 * ZERO_CROSSINGS; k++) begin
                if (col == COL_POS) begin
                    word = 16'sh7FFF;
                end else if (col == COL_NEG) begin
                    word = 16'sh8000;
                end else begin
                    word = RES_W'($urandom());
                end
                send_cmd(OP_LOAD, TIDX_W'(k * OVERSAMPLING + col), word,
                         AMP_W'($urandom()), FRAC_W'($urandom()));
            end
        end

        // Directed commands. A next on an empty ring gives zero. A step at
        // frac one reads phase zero over the full walk; frac zero gives
        // the top phase, where the walk stops one slot early at the table
        // end. Fracs above one clamp, and 512/513 sit on either side of a
        // rounding boundary. No index can lie beyond the table at this
        // size, so the ignored-load case cannot be reached.
        send_cmd(OP_NEXT,  '0, '0, '0, '0);
        send_cmd(OP_SCHED, '0, '0, 16'sh7FFF, FRAC_ONE);
        send_cmd(OP_NEXT,  '0, '0, '0, '0);
        send_cmd(OP_NEXT,  '0, '0, '0, '0);
        send_cmd(OP_SCHED, '0, '0, 16'sh8000, '0);
        send_cmd(OP_SCHED, '0, '0, 16'sh8000, FRAC_MAX);
        send_cmd(OP_SCHED, '0, '0, 16'sh0001, FRAC_W'(65537));
        send_cmd(OP_SCHED, '0, '0, -16'sh0001, FRAC_W'(512));
        send_cmd(OP_SCHED, '0, '0, 16'sh0000, FRAC_W'(513));
        send_cmd(OP_SCHED, '0, '0, 16'sh3039, FRAC_W'(32768));
        send_cmd(OP_LOAD,  TIDX_W'(TABLE_LEN - 1), 16'sh8000, '0, '0);
        send_cmd(OP_LOAD,  '0, 16'sh7FFF, '0, '0);
        send_cmd(OP_SPARE, '1, '1, '1, '1);
        send_cmd(OP_SCHED, '0, '0, 16'sh7FFF, '0);
        send_cmd(OP_NEXT,  '0, '0, '0, '0);
        send_cmd(OP_NEXT,  '0, '0, '0, '0);
        send_cmd(OP_NEXT,  '0, '0, '0, '0);
        send_cmd(OP_SCHED, '0, '0, 16'sh8000, FRAC_ONE);
        send_cmd(OP_NEXT,  '0, '0, '0, '0);

        // The sender goes silent until all samples are back, so the result
        // side also sees a fully drained block.
        hold_until_drained();

        random_cmds(150);
        hold_until_drained();
        pile_up(1'b0, 270);
        random_cmds(150);
        pile_up(1'b1, 270);
        random_cmds(200);

        @(negedge clk);
        item_ch.valid <= 1'b0;
        while (pending_count != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);

        if (error_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
